>>> src/dbdu_pkg.sv
`default_nettype none
package dbdu_pkg;

  localparam logic [2:0] KIND_FREXP = 3'd0;
  localparam logic [2:0] KIND_LDEXP = 3'd1;
  localparam logic [2:0] KIND_MODF  = 3'd2;
  localparam logic [2:0] KIND_ISINF = 3'd3;
  localparam logic [2:0] KIND_ISNAN = 3'd4;
  localparam logic [2:0] KIND_MKINF = 3'd5;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF   = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] NAN_POS_INF_FRAC = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] NAN_NEG_INF_FRAC = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;
  localparam logic [10:0] EXP_HALF  = 11'd1022;
  localparam logic [10:0] EXP_INT   = 11'd1075;

  typedef struct packed {
    logic [63:0]        main_bits;
    logic [63:0]        ip_bits;
    logic signed [11:0] expo;
    logic               flag;
    logic               norm;   // modf fraction still to be normalised
    logic               sgn;
    logic [10:0]        field;
    logic [51:0]        frac;
  } stage_t;

endpackage
`default_nettype wire

>>> src/double_bit_decompose_unit.sv
`default_nettype none
// Accepted transactions pass through a_r, b_r and the output registers.
// Throughput: one transaction per cycle unless stalled; stages are decode,
// leading-one search over the modf fraction, and normalise/assemble.
// Stalls hold each stage only while the one after it is full and held.
// Reset (synchronous, rst_n low) clears all valid bits; data is not reset.
module double_bit_decompose_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_kind,
  input  wire logic [63:0]        in_value_bits,
  input  wire logic signed [15:0] in_exp_adjust,
  input  wire logic signed [1:0]  in_sign_select,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             out_main_bits,
  output logic [63:0]             out_integer_part_bits,
  output logic signed [11:0]      out_exponent_out,
  output logic                    out_test_flag
);
  import dbdu_pkg::*;

  stage_t dec;
  stage_t a_r, b_r;
  logic   a_valid_r, b_valid_r, out_valid_r;
  logic [5:0] b_lead_r;
  logic [5:0] lead_nxt;
  logic   a_adv, b_adv, o_adv;
  logic [63:0] main_nxt;
  logic [11:0] fexp;
  logic [51:0] fsh;

  dbdu_decode u_dec (
    .kind (in_kind),
    .x    (in_value_bits),
    .adj  (in_exp_adjust),
    .sel  (in_sign_select),
    .res  (dec)
  );

  assign o_adv    = !out_valid_r || !out_stall;
  assign b_adv    = !b_valid_r || o_adv;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_stall = !a_adv;

  // highest set bit of the leftover fraction
  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < 52; i++)
      if (a_r.frac[i]) lead_nxt = 6'(i);
  end

  always_comb begin
    fexp     = {1'b0, b_r.field} + {6'd0, b_lead_r} - 12'd52;
    fsh      = b_r.frac << (6'd52 - b_lead_r);
    main_nxt = b_r.main_bits;
    if (b_r.norm) begin
      if (b_r.frac == '0) main_nxt = {b_r.sgn, 63'd0};
      else                main_nxt = {b_r.sgn, fexp[10:0], fsh};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) a_valid_r   <= in_valid;
      if (b_adv) b_valid_r   <= a_valid_r;
      if (o_adv) out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) a_r <= dec;
    if (b_adv) begin
      b_r      <= a_r;
      b_lead_r <= lead_nxt;
    end
    if (o_adv) begin
      out_main_bits         <= main_nxt;
      out_integer_part_bits <= b_r.ip_bits;
      out_exponent_out      <= b_r.expo;
      out_test_flag         <= b_r.flag;
    end
  end

  assign out_valid = out_valid_r;

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> a_valid_r)
    else $error("accepted transaction not captured");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_main_bits))
    else $error("held result changed");
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_test_flag |-> out_main_bits == 64'd0 &&
    out_integer_part_bits == 64'd0)
    else $error("test flag with nonzero payload");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !a_valid_r && !b_valid_r)
    else $error("valid bits not cleared by reset");
endmodule
`default_nettype wire

>>> src/dbdu_decode.sv
`default_nettype none
module dbdu_decode (
  input  wire logic [2:0]         kind,
  input  wire logic [63:0]        x,
  input  wire logic signed [15:0] adj,
  input  wire logic signed [1:0]  sel,
  output dbdu_pkg::stage_t        res
);
  import dbdu_pkg::*;

  logic [62:0]        mag;
  logic               sgn;
  logic [10:0]        field;
  logic signed [17:0] esum;
  logic               is_pinf;
  logic               is_ninf;
  logic               inf_any;
  logic [5:0]         nbits;
  logic [52:0]        mask;
  logic [51:0]        fr;
  logic [63:0]        tr;

  always_comb begin
    mag     = x[62:0];
    sgn     = x[63];
    field   = x[62:52];
    esum    = 18'(adj) + $signed({7'd0, field});
    is_pinf = (x == POS_INF);
    is_ninf = (x == NEG_INF);
    inf_any = is_pinf || is_ninf;
    nbits   = (field > EXP_INT) ? 6'd0 : 6'(EXP_INT - field);
    mask    = (53'd1 << nbits) - 53'd1;
    fr      = mag[51:0] & mask[51:0];
    tr      = {1'b0, mag[62:52], mag[51:0] & ~mask[51:0]};

    res       = '0;
    res.sgn   = sgn;
    res.field = field;
    case (kind)
      KIND_FREXP: begin
        if (mag != '0) begin
          res.expo      = $signed({1'b0, field}) - $signed({1'b0, EXP_HALF});
          res.main_bits = {sgn, EXP_HALF, x[51:0]};
        end
      end
      KIND_LDEXP: begin
        if (mag != '0) begin
          if (esum <= 18'sd0)
            res.main_bits = '0;
          else if (esum >= $signed({7'd0, EXP_MAX}))
            res.main_bits = (sgn && {1'b0, mag} <= POS_INF) ? NEG_INF : POS_INF;
          else
            res.main_bits = {sgn, esum[10:0], x[51:0]};
        end
      end
      KIND_MODF: begin
        if ({1'b0, mag} > POS_INF) begin
          res.ip_bits   = x;
          res.main_bits = x | QUIET_BIT;
        end else if ({1'b0, mag} == POS_INF) begin
          res.ip_bits   = x;
          res.main_bits = sgn ? NAN_NEG_INF_FRAC : NAN_POS_INF_FRAC;
        end else if (x == SIGN_BIT) begin
          res.main_bits = x;
        end else if ({1'b0, mag} < ONE_BITS) begin
          res.ip_bits   = {sgn, 63'd0};
          res.main_bits = x;
        end else begin
          res.ip_bits = {sgn, tr[62:0]};
          res.norm    = 1'b1;
          res.frac    = fr;
        end
      end
      KIND_ISINF: begin
        if (sel == 2'sd0)
          res.flag = inf_any;
        else if (!sel[1])
          res.flag = is_pinf;
        else
          res.flag = is_ninf;
      end
      KIND_ISNAN: res.flag = (field == EXP_MAX) && !inf_any;
      KIND_MKINF: res.main_bits = sel[1] ? NEG_INF : POS_INF;
      default: res = '0;
    endcase
  end
endmodule
`default_nettype wire
